// ----- src/embedding_table_gather_train_macros.svh -----
// assertion macros for the embedding table engine
// no dependencies; the files that assert include this header
`ifndef EMBEDDING_TABLE_GATHER_TRAIN_MACROS_SVH
`define EMBEDDING_TABLE_GATHER_TRAIN_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication, checked on every rising edge of clock
`define ETGT_ASSERT_IMP(lbl, pre, post) \
   lbl: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error("etgt assertion failed");
// next-cycle implication
`define ETGT_ASSERT_NEXT(lbl, pre, post) \
   lbl: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error("etgt assertion failed");
`else
`define ETGT_ASSERT_IMP(lbl, pre, post)
`define ETGT_ASSERT_NEXT(lbl, pre, post)
`endif
`endif

// ----- src/etgt_pkg.sv -----
// shared types and constants of the embedding table engine
// no dependencies
package etgt_pkg;

   typedef enum logic [2:0] {
      OP_LOOKUP = 3'd0,
      OP_ACCUM  = 3'd1,
      OP_CLEAR  = 3'd2,
      OP_UPDATE = 3'd3,
      OP_LOAD   = 3'd4
   } opcode_type;

   typedef enum logic [2:0] {
      ST_INIT,
      ST_IDLE,
      ST_LOOKUP,
      ST_ACC_RD,
      ST_ACC_WR,
      ST_CLEAR,
      ST_UPDATE,
      ST_DRAIN
   } state_type;

   typedef struct packed {
      logic [2:0]         opcode;
      logic [9:0]         token;
      logic [5:0]         column;
      logic signed [15:0] value;
   } req_item_type;

   typedef struct packed {
      logic signed [15:0] weight;
      logic [5:0]         position;
      logic               last;
   } rsp_item_type;

   // classified command held between front and back
   typedef struct packed {
      opcode_type         op;
      logic [9:0]         token;
      logic [5:0]         column;
      logic signed [15:0] value;
   } cmd_type;

   typedef struct packed {
      logic init_busy;
   } back_status_type;

   localparam int CMD_DEPTH = 2;
   localparam int RSP_DEPTH = 4;
   localparam int TOK_EXT_W = 17;

   localparam logic [15:0] RATE_RESET = 16'd655;

   localparam logic signed [23:0] ACC_MAX = 24'sh7FFFFF;
   localparam logic signed [23:0] ACC_MIN = 24'sh800000;
   localparam logic signed [15:0] W_MAX   = 16'sh7FFF;
   localparam logic signed [15:0] W_MIN   = 16'sh8000;

endpackage

// ----- src/etgt_fifo.sv -----
// small register queue, used for the command and result queues
// no package dependency
module etgt_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2,
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
   localparam int CNT_W = $clog2(DEPTH) + 1
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             pop,
   output logic [WIDTH-1:0] rd_data,
   output logic             empty,
   output logic             full,
   output logic [CNT_W-1:0] count
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      count_in = count_ff + CNT_W'(push) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

   assign rd_data = mem_ff[rd_ptr_ff];
   assign empty   = (count_ff == '0);
   assign full    = (count_ff == CNT_W'(DEPTH));
   assign count   = count_ff;

endmodule

// ----- src/etgt_front.sv -----
// front end: accepts request items, range-checks them and queues commands
// depends on etgt_pkg
module etgt_front #(
   parameter int VOCAB = 1024,
   parameter int DIM   = 64
) (
   input  etgt_pkg::req_item_type    req_data,
   input  logic                      push,
   output logic                      full,
   input  etgt_pkg::back_status_type status,
   input  logic                      cmd_full,
   output logic                      cmd_push,
   output etgt_pkg::cmd_type         cmd_data
);

   import etgt_pkg::*;

   logic tok_ok;
   logic col_ok;
   logic keep;
   logic accept;

   assign tok_ok = (TOK_EXT_W'(req_data.token) < TOK_EXT_W'(VOCAB));
   assign col_ok = (7'(req_data.column) < 7'(DIM));

   // items that cause nothing are dropped here and never reach the back end
   always_comb begin
      keep        = 1'b0;
      cmd_data.op = OP_LOOKUP;
      case (req_data.opcode)
         OP_LOOKUP: begin
            keep        = tok_ok;
            cmd_data.op = OP_LOOKUP;
         end
         OP_ACCUM: begin
            keep        = tok_ok && col_ok;
            cmd_data.op = OP_ACCUM;
         end
         OP_CLEAR: begin
            keep        = 1'b1;
            cmd_data.op = OP_CLEAR;
         end
         OP_UPDATE: begin
            keep        = 1'b1;
            cmd_data.op = OP_UPDATE;
         end
         OP_LOAD: begin
            keep        = tok_ok && col_ok;
            cmd_data.op = OP_LOAD;
         end
         default: begin
            keep        = 1'b0;
            cmd_data.op = OP_LOOKUP;
         end
      endcase
      cmd_data.token  = req_data.token;
      cmd_data.column = req_data.column;
      cmd_data.value  = req_data.value;
   end

   assign full     = cmd_full || status.init_busy;
   assign accept   = push && !full;
   assign cmd_push = accept && keep;

endmodule

// ----- src/etgt_back.sv -----
// back end: weight and gradient memories, lookup streaming, accumulate, load,
// clear sweep and pipelined update sweep; depends on etgt_pkg and the macro header
`include "embedding_table_gather_train_macros.svh"
module etgt_back #(
   parameter int VOCAB = 1024,
   parameter int DIM   = 64,
   localparam int RSP_CNT_W = $clog2(etgt_pkg::RSP_DEPTH) + 1
) (
   input  logic                      clock,
   input  logic                      reset,
   input  etgt_pkg::cmd_type         cmd_data,
   input  logic                      cmd_empty,
   output logic                      cmd_pop,
   input  logic [15:0]               rate,
   input  logic [RSP_CNT_W-1:0]      rsp_count,
   output logic                      rsp_push,
   output etgt_pkg::rsp_item_type    rsp_data,
   output etgt_pkg::back_status_type status
);

   import etgt_pkg::*;

   localparam int ROW_W  = (VOCAB > 1) ? $clog2(VOCAB) : 1;
   localparam int COL_W  = (DIM > 1) ? $clog2(DIM) : 1;
   localparam int ADDR_W = ROW_W + COL_W;
   localparam int MEM_DEPTH = 2 ** ADDR_W;
   localparam logic [COL_W-1:0] LAST_COL = COL_W'(DIM - 1);

   // memories
   logic signed [15:0] weight_mem_ff [MEM_DEPTH];
   logic signed [23:0] grad_mem_ff   [MEM_DEPTH];
   logic signed [15:0] w_q_ff;
   logic signed [23:0] g_q_ff;

   // sequencer
   state_type          state_ff, state_in;
   logic [ADDR_W-1:0]  sweep_ff, sweep_in;
   logic [COL_W-1:0]   col_ff, col_in;
   cmd_type            cur_ff, cur_in;

   // lookup read pipeline
   logic               rd_v_ff, rd_v_in;
   logic [COL_W-1:0]   rd_col_ff, rd_col_in;
   logic               rd_last_ff, rd_last_in;

   // update pipeline
   logic               u_v0_ff, u_v0_in;
   logic [ADDR_W-1:0]  u_a0_ff, u_a0_in;
   logic               u_v1_ff, u_v1_in;
   logic [ADDR_W-1:0]  u_a1_ff, u_a1_in;
   logic signed [15:0] u_w1_ff, u_w1_in;
   logic signed [24:0] delta_ff, delta_in;

   logic [TOK_EXT_W-1:0] cur_tok_ext;
   logic [TOK_EXT_W-1:0] head_tok_ext;
   logic [ADDR_W-1:0]    cur_addr;
   logic [ADDR_W-1:0]    head_addr;
   logic [ADDR_W-1:0]    w_rd_addr;
   logic [ADDR_W-1:0]    g_rd_addr;
   logic                 w_load_we;
   logic                 w_we;
   logic [ADDR_W-1:0]    w_wa;
   logic signed [15:0]   w_wd;
   logic                 g_we;
   logic [ADDR_W-1:0]    g_wa;
   logic signed [23:0]   g_wd;
   logic                 lk_issue;
   logic                 u_issue;
   logic                 rsp_room;
   logic signed [24:0]   acc_sum;
   logic signed [23:0]   acc_sat;
   logic signed [40:0]   prod;
   logic signed [25:0]   diff;
   logic signed [15:0]   w_new;

   assign cur_tok_ext  = TOK_EXT_W'(cur_ff.token);
   assign head_tok_ext = TOK_EXT_W'(cmd_data.token);
   assign cur_addr  = {cur_tok_ext[ROW_W-1:0], cur_ff.column[COL_W-1:0]};
   assign head_addr = {head_tok_ext[ROW_W-1:0], cmd_data.column[COL_W-1:0]};

   assign rsp_room = (rsp_count + RSP_CNT_W'(rd_v_ff)) < RSP_CNT_W'(RSP_DEPTH);

   // saturating gradient accumulate
   always_comb begin
      acc_sum = {g_q_ff[23], g_q_ff} + {{9{cur_ff.value[15]}}, cur_ff.value};
      if (acc_sum[24] != acc_sum[23]) begin
         acc_sat = acc_sum[24] ? ACC_MIN : ACC_MAX;
      end else begin
         acc_sat = acc_sum[23:0];
      end
   end

   // update: multiply stage, then floor shift, subtract and saturate
   assign prod     = $signed({1'b0, rate}) * g_q_ff;
   assign delta_in = prod[40:16];
   assign diff     = {{10{u_w1_ff[15]}}, u_w1_ff} - {delta_ff[24], delta_ff};
   always_comb begin
      if ((diff[25:15] != '0) && (diff[25:15] != '1)) begin
         w_new = diff[25] ? W_MIN : W_MAX;
      end else begin
         w_new = diff[15:0];
      end
   end

   always_comb begin
      state_in   = state_ff;
      sweep_in   = sweep_ff;
      col_in     = col_ff;
      cur_in     = cur_ff;
      cmd_pop    = 1'b0;
      lk_issue   = 1'b0;
      u_issue    = 1'b0;
      w_load_we  = 1'b0;
      w_rd_addr  = {cur_tok_ext[ROW_W-1:0], col_ff};
      g_rd_addr  = cur_addr;
      g_we       = 1'b0;
      g_wa       = cur_addr;
      g_wd       = '0;
      case (state_ff)
         ST_INIT, ST_CLEAR: begin
            g_we     = 1'b1;
            g_wa     = sweep_ff;
            g_wd     = '0;
            sweep_in = sweep_ff + 1'b1;
            if (sweep_ff == '1) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (!cmd_empty) begin
               cmd_pop  = 1'b1;
               cur_in   = cmd_data;
               col_in   = '0;
               sweep_in = '0;
               case (cmd_data.op)
                  OP_LOOKUP: state_in = ST_LOOKUP;
                  OP_ACCUM:  state_in = ST_ACC_RD;
                  OP_CLEAR:  state_in = ST_CLEAR;
                  OP_UPDATE: state_in = ST_UPDATE;
                  OP_LOAD:   w_load_we = 1'b1;
                  default:   state_in = ST_IDLE;
               endcase
            end
         end
         ST_LOOKUP: begin
            if (rsp_room) begin
               lk_issue = 1'b1;
               col_in   = col_ff + 1'b1;
               if (col_ff == LAST_COL) begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_ACC_RD: begin
            state_in = ST_ACC_WR;
         end
         ST_ACC_WR: begin
            g_we     = 1'b1;
            g_wd     = acc_sat;
            state_in = ST_IDLE;
         end
         ST_UPDATE: begin
            u_issue   = 1'b1;
            w_rd_addr = sweep_ff;
            g_rd_addr = sweep_ff;
            sweep_in  = sweep_ff + 1'b1;
            if (sweep_ff == '1) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!u_v0_ff && !u_v1_ff) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rd_v_in    = lk_issue;
   assign rd_col_in  = col_ff;
   assign rd_last_in = (col_ff == LAST_COL);
   assign u_v0_in    = u_issue;
   assign u_a0_in    = sweep_ff;
   assign u_v1_in    = u_v0_ff;
   assign u_a1_in    = u_a0_ff;
   assign u_w1_in    = w_q_ff;

   // weight write port: update write-back or load, never both
   assign w_we = w_load_we || u_v1_ff;
   assign w_wa = u_v1_ff ? u_a1_ff : head_addr;
   assign w_wd = u_v1_ff ? w_new : cmd_data.value;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_INIT;
         sweep_ff <= '0;
         rd_v_ff  <= 1'b0;
         u_v0_ff  <= 1'b0;
         u_v1_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         sweep_ff <= sweep_in;
         rd_v_ff  <= rd_v_in;
         u_v0_ff  <= u_v0_in;
         u_v1_ff  <= u_v1_in;
      end
   end

   always_ff @(posedge clock) begin
      col_ff     <= col_in;
      cur_ff     <= cur_in;
      rd_col_ff  <= rd_col_in;
      rd_last_ff <= rd_last_in;
      u_a0_ff    <= u_a0_in;
      u_a1_ff    <= u_a1_in;
      u_w1_ff    <= u_w1_in;
      delta_ff   <= delta_in;
   end

   always_ff @(posedge clock) begin
      w_q_ff <= weight_mem_ff[w_rd_addr];
      if (w_we) begin
         weight_mem_ff[w_wa] <= w_wd;
      end
   end

   always_ff @(posedge clock) begin
      g_q_ff <= grad_mem_ff[g_rd_addr];
      if (g_we) begin
         grad_mem_ff[g_wa] <= g_wd;
      end
   end

   assign rsp_push          = rd_v_ff;
   assign rsp_data.weight   = w_q_ff;
   assign rsp_data.position = 6'(rd_col_ff);
   assign rsp_data.last     = rd_last_ff;
   assign status.init_busy  = (state_ff == ST_INIT);

   `ETGT_ASSERT_IMP(a_rsp_room, rsp_push, rsp_count < RSP_CNT_W'(RSP_DEPTH))
   `ETGT_ASSERT_IMP(a_init_no_pop, state_ff == ST_INIT, !cmd_pop)
   `ETGT_ASSERT_IMP(a_wport_excl, u_v1_ff, !w_load_we)
   `ETGT_ASSERT_NEXT(a_last_follows, lk_issue && rd_last_in, rd_v_ff && rsp_data.last)

endmodule

// ----- src/embedding_table_gather_train.sv -----
// top level of the embedding table engine: csr register, front end,
// command queue, back end and result queue; depends on etgt_pkg and its modules
//
//  channel   ports                          accepted when
//  request   push, full, req_data           push && !full
//  result    empty, pop, rsp_data           pop && !empty
//  csr       csr_valid, csr_ready, csr_data csr_valid && csr_ready
//
// after reset the gradient memory is cleared one entry a cycle, 2**clog2(VOCAB) rows
// by 2**clog2(DIM) columns; full stays high meanwhile
// lookup: one element a cycle, stalled only by a full result queue, via the command
// queue, the IDLE and LOOKUP states, the weight read register and the result queue;
// accumulate: ACC_RD then ACC_WR; load writes in IDLE; clear and update: one entry a
// cycle over the whole table, update then DRAIN; one command at a time in the back end
`include "embedding_table_gather_train_macros.svh"
module embedding_table_gather_train #(
   parameter int VOCAB = 1024,
   parameter int DIM   = 64
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   output logic                   full,
   input  etgt_pkg::req_item_type req_data,
   output logic                   empty,
   input  logic                   pop,
   output etgt_pkg::rsp_item_type rsp_data,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [15:0]            csr_data
);

   import etgt_pkg::*;

   localparam int CMD_CNT_W = $clog2(CMD_DEPTH) + 1;
   localparam int RSP_CNT_W = $clog2(RSP_DEPTH) + 1;

   // learning rate, unsigned q0.16
   logic [15:0] rate_ff, rate_in;

   back_status_type        status;
   logic                   cmd_push;
   cmd_type                cmd_wr;
   logic [$bits(cmd_type)-1:0] cmd_rd_raw;
   cmd_type                cmd_rd;
   logic                   cmd_pop;
   logic                   cmd_empty;
   logic                   cmd_full;
   logic [CMD_CNT_W-1:0]   cmd_count;

   logic                   rsp_push;
   rsp_item_type           rsp_wr;
   logic [$bits(rsp_item_type)-1:0] rsp_rd_raw;
   logic                   rsp_full;
   logic [RSP_CNT_W-1:0]   rsp_count;
   logic                   rsp_pop;

   // csr port is always ready; write only while no item is in flight
   assign csr_ready = 1'b1;
   assign rate_in   = (csr_valid && csr_ready) ? csr_data : rate_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rate_ff <= RATE_RESET;
      end else begin
         rate_ff <= rate_in;
      end
   end

   // front end: range checks, drops items that have no effect
   etgt_front #(
      .VOCAB (VOCAB),
      .DIM   (DIM)
   ) u_front (
      .req_data (req_data),
      .push     (push),
      .full     (full),
      .status   (status),
      .cmd_full (cmd_full),
      .cmd_push (cmd_push),
      .cmd_data (cmd_wr)
   );

   // command queue decouples the front end from the back end
   etgt_fifo #(
      .WIDTH ($bits(cmd_type)),
      .DEPTH (CMD_DEPTH)
   ) u_cmd_q (
      .clock   (clock),
      .reset   (reset),
      .push    (cmd_push),
      .wr_data (cmd_wr),
      .pop     (cmd_pop),
      .rd_data (cmd_rd_raw),
      .empty   (cmd_empty),
      .full    (cmd_full),
      .count   (cmd_count)
   );

   assign cmd_rd = cmd_type'(cmd_rd_raw);

   // back end: memories and sequencer
   etgt_back #(
      .VOCAB (VOCAB),
      .DIM   (DIM)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_data  (cmd_rd),
      .cmd_empty (cmd_empty),
      .cmd_pop   (cmd_pop),
      .rate      (rate_ff),
      .rsp_count (rsp_count),
      .rsp_push  (rsp_push),
      .rsp_data  (rsp_wr),
      .status    (status)
   );

   // result queue; the back end only issues a read when a slot is reserved
   assign rsp_pop = pop && !empty;

   etgt_fifo #(
      .WIDTH ($bits(rsp_item_type)),
      .DEPTH (RSP_DEPTH)
   ) u_rsp_q (
      .clock   (clock),
      .reset   (reset),
      .push    (rsp_push),
      .wr_data (rsp_wr),
      .pop     (rsp_pop),
      .rd_data (rsp_rd_raw),
      .empty   (empty),
      .full    (rsp_full),
      .count   (rsp_count)
   );

   assign rsp_data = rsp_item_type'(rsp_rd_raw);

   `ETGT_ASSERT_IMP(a_rsp_no_overflow, rsp_push, !rsp_full)
   `ETGT_ASSERT_IMP(a_cmd_no_overflow, cmd_push, cmd_count < CMD_CNT_W'(CMD_DEPTH))
   `ETGT_ASSERT_IMP(a_cmd_pop_valid, cmd_pop, !cmd_empty)

endmodule
